// ===== rtl/lptr_pkg.sv =====
// Shared types and constants for the lidar point transform router.
// Holds the configuration register struct, register indexes and route codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lptr_pkg;

  // Default datapath sizes
  localparam int COORD_WIDTH_DEF   = 16;
  localparam int ROT_FRAC_BITS_DEF = 14;

  // Fixed register field formats
  localparam int ROT_W      = 16;
  localparam int LIMIT_W    = 16;
  localparam int RANGE_W    = 15;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 48;

  // Queue between the front and the back (power of two)
  localparam int QUEUE_DEPTH = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROT_X     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_H    = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_RNG  = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_H     = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL      = 8'd7;

  // Reset values of the rotation rows (identity matrix in Q2.14)
  localparam logic [47:0] ROT_ROW_X_RST = 48'h0000_0000_4000;
  localparam logic [47:0] ROT_ROW_Y_RST = 48'h0000_4000_0000;
  localparam logic [47:0] ROT_ROW_Z_RST = 48'h4000_0000_0000;

  // Control flag bit positions
  localparam int CTRL_REGION   = 0;
  localparam int CTRL_FLOOR    = 1;
  localparam int CTRL_SZMIN_EN = 2;
  localparam int CTRL_SZMAX_EN = 3;
  localparam int CTRL_RANGE_EN = 4;
  localparam int CTRL_OZMIN_EN = 5;
  localparam int CTRL_OZMAX_EN = 6;

  // Route codes
  localparam logic [1:0] ROUTE_SCAN    = 2'd0;
  localparam logic [1:0] ROUTE_HELD    = 2'd1;
  localparam logic [1:0] ROUTE_DISCARD = 2'd2;
  localparam logic [1:0] ROUTE_INVALID = 2'd3;

  // Configuration register file contents
  typedef struct packed {
    logic [2:0][47:0]     rot;
    logic [47:0]          trans;
    logic [31:0]          scan_h;
    logic [RANGE_W-1:0]   scan_range;
    logic [31:0]          out_h;
    logic [6:0]           ctrl;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/lptr_front.sv =====
// Front of the router: accepts input points and classifies them as valid or not.
// Holds one point and pushes it into the queue. Depends on nothing but its ports.
`timescale 1ns / 1ps
`default_nettype none

module lptr_front #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_z,
  input  wire logic                          in_point_valid,
  input  wire logic                          q_full,
  output logic                               q_push,
  output logic [3*COORD_WIDTH:0]             q_wdata
);

  logic                     hold_valid_r;
  logic                     hold_valid_nxt;
  logic [3*COORD_WIDTH:0]   hold_data_r;
  logic                     accept;

  // Handshake with the source and the queue
  assign q_push   = hold_valid_r && !q_full;
  assign in_stall = hold_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_wdata  = hold_data_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (q_push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // Classify: an invalid point carries zero coordinates and a clear flag
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_point_valid) begin
        hold_data_r <= {in_point_x, in_point_y, in_point_z, 1'b1};
      end else begin
        hold_data_r <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lptr_queue.sv =====
// Short FIFO between the front and the back of the router.
// Depth comes from lptr_pkg::QUEUE_DEPTH; width is a parameter.
`timescale 1ns / 1ps
`default_nettype none

module lptr_queue #(
  parameter int WIDTH = 49
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int AW    = $clog2(lptr_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(lptr_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_r [lptr_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full  = (count_r == CNT_W'(lptr_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue popped while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue count did not track a push");
`endif

endmodule

`default_nettype wire

// ===== rtl/lptr_back.sv =====
// Back of the router: rotation, rounding, translation, saturation and routing.
// Five-stage pipeline fed from the queue; uses lptr_pkg for cfg_t and codes.
`timescale 1ns / 1ps
`default_nettype none

module lptr_back #(
  parameter int COORD_WIDTH   = 16,
  parameter int ROT_FRAC_BITS = 14
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lptr_pkg::cfg_t                cfg,
  input  wire logic                          q_empty,
  input  wire logic [3*COORD_WIDTH:0]        q_rdata,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0]      out_x,
  output logic signed [COORD_WIDTH-1:0]      out_y,
  output logic signed [COORD_WIDTH-1:0]      out_z,
  output logic [1:0]                         out_route
);

  localparam int CW = COORD_WIDTH;
  localparam int RW = lptr_pkg::ROT_W;
  localparam int PW = RW + CW;
  localparam int SW = PW + 2;
  localparam int TW = SW + 1;
  localparam int LW = 2 * lptr_pkg::RANGE_W;
  localparam int DW = (2 * CW + 1 > LW) ? 2 * CW + 1 : LW;

  localparam logic signed [SW-1:0] RND  = SW'(64'd1 << (ROT_FRAC_BITS - 1));
  localparam logic signed [TW-1:0] QMAX = TW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [TW-1:0] QMIN = ~QMAX;

  // Stage valids and the common advance
  logic adv;
  logic v1_r, v2_r, v3_r, v4_r;
  logic out_valid_r;

  // Payload registers
  logic signed [PW-1:0] s1_prod_r [3][3];
  logic                 s1_inv_r;
  logic signed [SW-1:0] s2_acc_r [3];
  logic                 s2_inv_r;
  logic signed [CW-1:0] s3_q_r [3];
  logic                 s3_inv_r;
  logic signed [CW-1:0] s4_q_r [3];
  logic [2*CW-1:0]      s4_sqx_r;
  logic [2*CW-1:0]      s4_sqy_r;
  logic [LW-1:0]        s4_lim2_r;
  logic                 s4_rejz_r;
  logic                 s4_pass_r;
  logic                 s4_inv_r;
  logic signed [CW-1:0] out_x_r, out_y_r, out_z_r;
  logic [1:0]           out_route_r;

  // Combinational helpers
  logic signed [CW-1:0] pin [3];
  logic signed [SW-1:0] shifted [3];
  logic signed [TW-1:0] tsum [3];
  logic signed [CW-1:0] q_sat [3];
  logic [CW-1:0]        ax, ay;
  logic signed [CW-1:0] zq;
  logic                 en_szmin, en_szmax, en_rng, en_ozmin, en_ozmax;
  logic                 rejz_nxt, pass_nxt;
  logic [DW-1:0]        d2;
  logic                 rej;
  logic [1:0]           route_nxt;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  assign pin[0] = q_rdata[3*CW -: CW];
  assign pin[1] = q_rdata[2*CW -: CW];
  assign pin[2] = q_rdata[CW -: CW];

  // Stage valids: the whole back moves together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= q_pop;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  // Stage 1: nine products of rotation entries and coordinates
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s1_prod_r[i][j] <= $signed(cfg.rot[i][RW*j +: RW]) * pin[j];
        end
      end
      s1_inv_r <= !q_rdata[0];
    end
  end

  // Stage 2: row sums plus half an LSB for rounding
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s2_acc_r[i] <= s1_prod_r[i][0] + s1_prod_r[i][1] + s1_prod_r[i][2] + RND;
      end
      s2_inv_r <= s1_inv_r;
    end
  end

  // Stage 3: drop fraction, add translation, saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shifted[i] = s2_acc_r[i] >>> ROT_FRAC_BITS;
      tsum[i]    = shifted[i] + $signed(cfg.trans[16*i +: 16]);
      if (tsum[i] > QMAX) begin
        q_sat[i] = QMAX[CW-1:0];
      end else if (tsum[i] < QMIN) begin
        q_sat[i] = QMIN[CW-1:0];
      end else begin
        q_sat[i] = tsum[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s3_q_r[i] <= q_sat[i];
      end
      s3_inv_r <= s2_inv_r;
    end
  end

  // Stage 4: squares for planar range and the z tests
  assign en_szmin = cfg.ctrl[lptr_pkg::CTRL_REGION] && !cfg.ctrl[lptr_pkg::CTRL_FLOOR] &&
                    cfg.ctrl[lptr_pkg::CTRL_SZMIN_EN];
  assign en_szmax = cfg.ctrl[lptr_pkg::CTRL_REGION] && cfg.ctrl[lptr_pkg::CTRL_SZMAX_EN];
  assign en_rng   = cfg.ctrl[lptr_pkg::CTRL_REGION] && cfg.ctrl[lptr_pkg::CTRL_RANGE_EN];
  assign en_ozmin = cfg.ctrl[lptr_pkg::CTRL_OZMIN_EN];
  assign en_ozmax = cfg.ctrl[lptr_pkg::CTRL_OZMAX_EN];

  assign ax = s3_q_r[0][CW-1] ? CW'(~s3_q_r[0] + 1'b1) : s3_q_r[0];
  assign ay = s3_q_r[1][CW-1] ? CW'(~s3_q_r[1] + 1'b1) : s3_q_r[1];
  assign zq = s3_q_r[2];

  assign rejz_nxt = (en_szmin && (zq < $signed(cfg.scan_h[15:0]))) ||
                    (en_szmax && (zq > $signed(cfg.scan_h[31:16])));
  assign pass_nxt = !(en_ozmin && (zq < $signed(cfg.out_h[15:0]))) &&
                    !(en_ozmax && (zq > $signed(cfg.out_h[31:16])));

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s4_q_r[i] <= s3_q_r[i];
      end
      s4_sqx_r  <= ax * ax;
      s4_sqy_r  <= ay * ay;
      s4_lim2_r <= cfg.scan_range * cfg.scan_range;
      s4_rejz_r <= rejz_nxt;
      s4_pass_r <= pass_nxt;
      s4_inv_r  <= s3_inv_r;
    end
  end

  // Stage 5: range test and route decision into the output register
  assign d2  = DW'(s4_sqx_r) + DW'(s4_sqy_r);
  assign rej = s4_rejz_r || (en_rng && (d2 > DW'(s4_lim2_r)));

  always_comb begin
    priority if (s4_inv_r) begin
      route_nxt = lptr_pkg::ROUTE_INVALID;
    end else if (!rej) begin
      route_nxt = lptr_pkg::ROUTE_SCAN;
    end else if (s4_pass_r) begin
      route_nxt = lptr_pkg::ROUTE_HELD;
    end else begin
      route_nxt = lptr_pkg::ROUTE_DISCARD;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r     <= s4_inv_r ? '0 : s4_q_r[0];
      out_y_r     <= s4_inv_r ? '0 : s4_q_r[1];
      out_z_r     <= s4_inv_r ? '0 : s4_q_r[2];
      out_route_r <= route_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;
  assign out_route = out_route_r;

`ifndef ASSERT_OFF
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_route_r == lptr_pkg::ROUTE_INVALID |->
    out_x_r == '0 && out_y_r == '0 && out_z_r == '0)
    else $error("invalid point carries nonzero coordinates");
  a_last_stage_lands: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && adv |=> out_valid_r)
    else $error("item lost between last stage and output register");
  a_frozen_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({v1_r, v2_r, v3_r, v4_r}))
    else $error("pipeline moved while output was stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/lidar_point_transform_router.sv =====
// Throughput: one point per cycle while the input is not stalled; on an output stall
// the back pipeline freezes and the 4-entry queue absorbs it, and the input stalls
// only once the queue is full.
// Reset (rst_n low, synchronous): pipeline and queue empty, registers take their
// reset values (identity rotation, all limits, translation and flags zero).
`timescale 1ns / 1ps
`default_nettype none

module lidar_point_transform_router #(
  parameter int COORD_WIDTH   = lptr_pkg::COORD_WIDTH_DEF,
  parameter int ROT_FRAC_BITS = lptr_pkg::ROT_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Point input
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [COORD_WIDTH-1:0]       in_point_x,
  input  wire logic signed [COORD_WIDTH-1:0]       in_point_y,
  input  wire logic signed [COORD_WIDTH-1:0]       in_point_z,
  input  wire logic                                in_point_valid,
  // Result output
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [COORD_WIDTH-1:0]            out_x,
  output logic signed [COORD_WIDTH-1:0]            out_y,
  output logic signed [COORD_WIDTH-1:0]            out_z,
  output logic [1:0]                               out_route,
  // Register writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lptr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lptr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int QW = 3 * COORD_WIDTH + 1;

  lptr_pkg::cfg_t cfg_r;
  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  logic [QW-1:0]  q_wdata;
  logic [QW-1:0]  q_rdata;

  // Register file: always ready, out-of-range indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot[0]      <= lptr_pkg::ROT_ROW_X_RST;
      cfg_r.rot[1]      <= lptr_pkg::ROT_ROW_Y_RST;
      cfg_r.rot[2]      <= lptr_pkg::ROT_ROW_Z_RST;
      cfg_r.trans       <= '0;
      cfg_r.scan_h      <= '0;
      cfg_r.scan_range  <= '0;
      cfg_r.out_h       <= '0;
      cfg_r.ctrl        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lptr_pkg::REG_ROT_X:    cfg_r.rot[0]     <= cfg_data;
        lptr_pkg::REG_ROT_Y:    cfg_r.rot[1]     <= cfg_data;
        lptr_pkg::REG_ROT_Z:    cfg_r.rot[2]     <= cfg_data;
        lptr_pkg::REG_TRANS:    cfg_r.trans      <= cfg_data;
        lptr_pkg::REG_SCAN_H:   cfg_r.scan_h     <= cfg_data[31:0];
        lptr_pkg::REG_SCAN_RNG: cfg_r.scan_range <= cfg_data[lptr_pkg::RANGE_W-1:0];
        lptr_pkg::REG_OUT_H:    cfg_r.out_h      <= cfg_data[31:0];
        lptr_pkg::REG_CTRL:     cfg_r.ctrl       <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  lptr_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_z     (in_point_z),
    .in_point_valid (in_point_valid),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  lptr_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  lptr_back #(
    .COORD_WIDTH   (COORD_WIDTH),
    .ROT_FRAC_BITS (ROT_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_route (out_route)
  );

endmodule

`default_nettype wire

// ===== dv/tb_lidar_point_transform_router.sv =====
// Testbench for lidar_point_transform_router: directed and random point requests
// checked against a local transform and routing predictor.
// Depends on rtl/lptr_pkg.sv and rtl/lidar_point_transform_router.sv.
`timescale 1ns / 1ps

module tb_lidar_point_transform_router;

  localparam int COORD_W          = lptr_pkg::COORD_WIDTH_DEF;
  localparam int FRAC_W           = lptr_pkg::ROT_FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES    = 12;
  localparam int QUIET_LIMIT      = 1000;  // cycles with no handshake on any channel
  localparam int RANDOM_PHASES    = 8;
  localparam int POINTS_PER_PHASE = 55;
  localparam int MAX_REPORTS      = 10;

  // Indexes past the register file; writes there must be dropped
  localparam logic [lptr_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd8;
  localparam logic [lptr_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [1:0]                route;
  } point_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [COORD_W-1:0] in_point_x;
  logic signed [COORD_W-1:0] in_point_y;
  logic signed [COORD_W-1:0] in_point_z;
  logic in_point_valid;
  logic out_valid;
  logic out_stall;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic [1:0] out_route;
  logic cfg_valid;
  logic cfg_ready;
  logic [lptr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lptr_pkg::CFG_DATA_W-1:0] cfg_data;

  // Local copy of the register file
  logic [47:0]                  rot_row [3];
  logic [47:0]                  trans_reg;
  logic [31:0]                  scan_h_reg;
  logic [lptr_pkg::RANGE_W-1:0] scan_rng_reg;
  logic [31:0]                  out_h_reg;
  logic [6:0]                   ctrl_reg;

  point_result_t expected_points [$];
  int mismatches;
  int burst_left;

  lidar_point_transform_router #(
    .COORD_WIDTH  (COORD_W),
    .ROT_FRAC_BITS(FRAC_W)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .in_point_valid(in_point_valid),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_route     (out_route),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Signed 16-bit slot k of a packed register
  function automatic longint slot_of(logic [47:0] packed_val, int k);
    return longint'($signed(packed_val[16*k +: 16]));
  endfunction

  // Transform, saturate and route one point with the current register copy
  function automatic point_result_t transform_point(logic signed [COORD_W-1:0] px,
                                                    logic signed [COORD_W-1:0] py,
                                                    logic signed [COORD_W-1:0] pz,
                                                    logic pv);
    point_result_t r;
    longint p [3];
    longint q [3];
    longint acc;
    longint hi;
    longint lo;
    longint d2;
    longint lim;
    bit region;
    bit en_zmin;
    bit en_zmax;
    bit en_rng;
    bit rej;
    bit pass;
    r = '0;
    if (!pv) begin
      r.route = lptr_pkg::ROUTE_INVALID;
      return r;
    end
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    hi = (longint'(1) <<< (COORD_W - 1)) - 1;
    lo = -hi - 1;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += slot_of(rot_row[i], j) * p[j];
      // round half up, then floor
      acc = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
      acc += slot_of(trans_reg, i);
      q[i] = (acc > hi) ? hi : ((acc < lo) ? lo : acc);
    end
    region  = ctrl_reg[lptr_pkg::CTRL_REGION];
    en_zmin = region && !ctrl_reg[lptr_pkg::CTRL_FLOOR] && ctrl_reg[lptr_pkg::CTRL_SZMIN_EN];
    en_zmax = region && ctrl_reg[lptr_pkg::CTRL_SZMAX_EN];
    en_rng  = region && ctrl_reg[lptr_pkg::CTRL_RANGE_EN];
    d2  = q[0] * q[0] + q[1] * q[1];
    lim = longint'(scan_rng_reg);
    rej = (en_zmin && q[2] < slot_of(48'(scan_h_reg), 0)) ||
          (en_zmax && q[2] > slot_of(48'(scan_h_reg), 1)) ||
          (en_rng && d2 > lim * lim);
    pass = !(ctrl_reg[lptr_pkg::CTRL_OZMIN_EN] && q[2] < slot_of(48'(out_h_reg), 0)) &&
           !(ctrl_reg[lptr_pkg::CTRL_OZMAX_EN] && q[2] > slot_of(48'(out_h_reg), 1));
    r.x = q[0][COORD_W-1:0];
    r.y = q[1][COORD_W-1:0];
    r.z = q[2][COORD_W-1:0];
    r.route = !rej ? lptr_pkg::ROUTE_SCAN
                   : (pass ? lptr_pkg::ROUTE_HELD : lptr_pkg::ROUTE_DISCARD);
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] near_value(int span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - span;
    return COORD_W'(v);
  endfunction

  function automatic logic [47:0] rand_row();
    logic [47:0] row;
    for (int k = 0; k < 3; k++)
      row[16*k +: 16] = ($urandom_range(0, 9) < 7) ? near_value(16384) : 16'($urandom);
    return row;
  endfunction

  // One register write request; valid stays up for back-to-back writes
  task automatic write_reg(logic [lptr_pkg::CFG_IDX_W-1:0] idx,
                           logic [lptr_pkg::CFG_DATA_W-1:0] data, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last) cfg_valid <= 1'b0;
    case (idx)
      lptr_pkg::REG_ROT_X:    rot_row[0] = data;
      lptr_pkg::REG_ROT_Y:    rot_row[1] = data;
      lptr_pkg::REG_ROT_Z:    rot_row[2] = data;
      lptr_pkg::REG_TRANS:    trans_reg = data;
      lptr_pkg::REG_SCAN_H:   scan_h_reg = data[31:0];
      lptr_pkg::REG_SCAN_RNG: scan_rng_reg = data[lptr_pkg::RANGE_W-1:0];
      lptr_pkg::REG_OUT_H:    out_h_reg = data[31:0];
      lptr_pkg::REG_CTRL:     ctrl_reg = data[6:0];
      default: ;
    endcase
  endtask

  task automatic program_all(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2,
                             logic [47:0] tr, logic [47:0] sh, logic [47:0] sr,
                             logic [47:0] oh, logic [47:0] c);
    write_reg(lptr_pkg::REG_ROT_X, r0, 1'b0);
    write_reg(lptr_pkg::REG_ROT_Y, r1, 1'b0);
    write_reg(lptr_pkg::REG_ROT_Z, r2, 1'b0);
    write_reg(lptr_pkg::REG_TRANS, tr, 1'b0);
    write_reg(lptr_pkg::REG_SCAN_H, sh, 1'b0);
    write_reg(lptr_pkg::REG_SCAN_RNG, sr, 1'b0);
    write_reg(lptr_pkg::REG_OUT_H, oh, 1'b0);
    write_reg(lptr_pkg::REG_CTRL, c, 1'b1);
  endtask

  // Send one point request; bursts of random length with idle gaps between
  task automatic send_point(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                            logic signed [COORD_W-1:0] pz, logic pv);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid       <= 1'b1;
    in_point_x     <= px;
    in_point_y     <= py;
    in_point_z     <= pz;
    in_point_valid <= pv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_points.insert(expected_points.size(), transform_point(px, py, pz, pv));
    burst_left--;
  endtask

  // Hold off the sender until every pending result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reset configuration: identity, no routing stages, so every valid point scans
  task automatic test_identity_extremes();
    send_point(16'sh7FFF, 16'sh8000, 16'sh0000, 1'b1);
    send_point(16'sh8000, 16'sh7FFF, -16'sd1, 1'b1);
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_point(-16'sd1, 16'sd1, 16'sh7FFF, 1'b1);
    send_point(16'sd12345, -16'sd321, 16'sh8000, 1'b0);
    send_point(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
  endtask

  // Half-unit ties, full-scale coefficients and translation, saturation both ways
  task automatic test_rounding_saturation();
    wait_for_results();
    program_all(48'h0000_0000_2000, 48'h7FFF_7FFF_7FFF, 48'h8000_0000_8000,
                48'h7FFF_8000_0000, 48'h0, 48'h0, 48'h0, 48'h0);
    send_point(16'sd1, 16'sd0, 16'sd0, 1'b1);
    send_point(-16'sd1, 16'sd0, 16'sd0, 1'b1);
    send_point(16'sd3, -16'sd5, 16'sd7, 1'b1);
    send_point(-16'sd3, 16'sd5, -16'sd7, 1'b1);
    send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
    send_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
  endtask

  // Scan, held and discard routes, the range boundary, and the floor stage masking scan zmin
  task automatic test_routing();
    logic [6:0] all_but_floor;
    all_but_floor = '1;
    all_but_floor[lptr_pkg::CTRL_FLOOR] = 1'b0;
    wait_for_results();
    program_all(lptr_pkg::ROT_ROW_X_RST, lptr_pkg::ROT_ROW_Y_RST, lptr_pkg::ROT_ROW_Z_RST,
                48'h0, {16'sd500, -16'sd100}, 48'd1000, {16'sd2000, -16'sd2000},
                48'(all_but_floor));
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_point(16'sd600, 16'sd800, 16'sd0, 1'b1);
    send_point(16'sd600, 16'sd801, 16'sd0, 1'b1);
    send_point(16'sd0, 16'sd0, -16'sd101, 1'b1);
    send_point(16'sd0, 16'sd0, 16'sd501, 1'b1);
    send_point(16'sd0, 16'sd0, 16'sd2001, 1'b1);
    send_point(16'sd0, 16'sd0, -16'sd2001, 1'b1);
    wait_for_results();
    write_reg(lptr_pkg::REG_CTRL, 48'h7F, 1'b1);
    send_point(16'sd0, 16'sd0, -16'sd101, 1'b1);
    send_point(16'sd0, 16'sd0, -16'sd2001, 1'b1);
  endtask

  // Writes past the last register leave the configuration alone
  task automatic test_unused_index();
    wait_for_results();
    write_reg(REG_UNUSED_LO, '1, 1'b0);
    write_reg(REG_UNUSED_HI, '1, 1'b1);
    send_point(16'sd100, -16'sd200, 16'sd300, 1'b1);
    send_point(16'sd0, 16'sd0, -16'sd2001, 1'b1);
  endtask

  // Random configurations, including all-ones and all-zero, with random points
  task automatic test_random_phases();
    int pick;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_for_results();
      if (ph == 0) begin
        program_all('1, '1, '1, '1, '1, '1, '1, '1);
      end else if (ph == 1) begin
        program_all('0, '0, '0, '0, '0, '0, '0, '0);
      end else begin
        program_all(rand_row(), rand_row(), rand_row(),
                    ($urandom_range(0, 3) == 0) ? 48'({$urandom, $urandom})
                      : {near_value(1000), near_value(1000), near_value(1000)},
                    48'({near_value(2000), near_value(2000)}),
                    ($urandom_range(0, 7) == 0) ? 48'($urandom_range(0, 32767))
                      : 48'($urandom_range(0, 4000)),
                    48'({near_value(4000), near_value(4000)}),
                    48'($urandom_range(0, 127) | (($urandom_range(0, 3) != 0) ? 1 : 0)));
      end
      for (int n = 0; n < POINTS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 7)
          send_point(near_value(3000), near_value(3000), near_value(2000), 1'b1);
        else if (pick < 9)
          send_point(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        else
          send_point(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
      end
    end
  endtask

  // Receiver stall pattern: none, random, periodic, long stretches
  initial begin : receiver_stall
    int cyc;
    int run_left;
    cyc = 0;
    run_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      case ((cyc / 101) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ((cyc % 5) < 3);
        default: begin
          if (run_left > 0) run_left--;
          else if ($urandom_range(0, 99) < 5) run_left = $urandom_range(5, 25);
          out_stall <= (run_left > 0);
        end
      endcase
    end
  end

  // Compare each accepted result with the oldest pending prediction
  always @(posedge clk) begin : result_check
    point_result_t got;
    point_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{x: out_x, y: out_y, z: out_z, route: out_route};
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result x=%0d y=%0d z=%0d route=%0d",
                   $time, got.x, got.y, got.z, got.route);
      end else begin
        want = expected_points.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.route !== want.route) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"%0t: expected x=%0d y=%0d z=%0d route=%0d, ",
                      "got x=%0d y=%0d z=%0d route=%0d"},
                     $time, want.x, want.y, want.z, want.route,
                     got.x, got.y, got.z, got.route);
        end
      end
    end
  end

  // Watchdog: too long with no request accepted on any channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_point_x     <= '0;
    in_point_y     <= '0;
    in_point_z     <= '0;
    in_point_valid <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    mismatches = 0;
    burst_left = 0;
    rot_row[0]   = lptr_pkg::ROT_ROW_X_RST;
    rot_row[1]   = lptr_pkg::ROT_ROW_Y_RST;
    rot_row[2]   = lptr_pkg::ROT_ROW_Z_RST;
    trans_reg    = '0;
    scan_h_reg   = '0;
    scan_rng_reg = '0;
    out_h_reg    = '0;
    ctrl_reg     = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_identity_extremes();
    test_rounding_saturation();
    test_routing();
    test_unused_index();
    test_random_phases();
    wait_for_results();

    if (mismatches == 0 && expected_points.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
